// File: rtl/smas_pkg.sv
// shared types, constants and helpers of the small matrix add/sub/mul unit
`timescale 1ns / 1ps
package smas_pkg;

  // dimension limit: default and the top of its range
  localparam int unsigned MAX_DIM_DEF = 4;
  localparam int unsigned MAX_DIM_TOP = 16;

  // clamped dimension width, wide enough for the top of the range
  localparam int unsigned DIM_W      = $clog2(MAX_DIM_TOP + 1);
  // store address carried in a command, sized for the largest store
  localparam int unsigned CMD_ADDR_W = $clog2(MAX_DIM_TOP * MAX_DIM_TOP);

  localparam int unsigned CMD_FIFO_DEPTH = 4;

  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned RESULT_W = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2,
    CFG_OP    = 2'd3
  } cfg_idx_e;

  // op_mode bit meaning: bit 1 selects multiply, else bit 0 selects subtract
  localparam int unsigned OP_MUL_BIT = 1;
  localparam int unsigned OP_SUB_BIT = 0;

  localparam logic [2:0] ROWS_RST  = 3'd2;
  localparam logic [2:0] INNER_RST = 3'd3;
  localparam logic [2:0] COLS_RST  = 3'd2;
  localparam logic [1:0] OP_RST    = 2'd0;

  typedef struct packed {
    logic                     which_matrix;
    logic signed [ELEM_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic                       result_last;
  } out_item_t;

  // clamped dimensions and decoded operation
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
    logic             mul;
    logic             sub;
  } dims_t;

  typedef enum logic [1:0] {
    CMD_WR_A     = 2'd0,
    CMD_WR_B     = 2'd1,
    CMD_WR_B_RUN = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic [CMD_ADDR_W-1:0]    addr;
    logic signed [ELEM_W-1:0] data;
  } cmd_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // control that travels down the compute pipeline with each operand pair
  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
    logic last;
  } pipe_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [2:0]       v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] w;
    w = DIM_W'(v);
    if (w == '0) begin
      return DIM_W'(1);
    end else if (w > max_dim) begin
      return max_dim;
    end
    return w;
  endfunction

endpackage

// File: rtl/smas_front.sv
// front end: configuration registers, load counting and command generation
`timescale 1ns / 1ps
module smas_front #(
  parameter int unsigned MAX_DIM = smas_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [smas_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smas_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             push,
  input  smas_pkg::in_item_t               in_item_i,
  output logic                             full,
  output smas_pkg::dims_t                  dims_o,
  output logic                             cmd_valid_o,
  output smas_pkg::cmd_t                   cmd_o,
  input  logic                             cmd_full_i
);

  localparam int unsigned SW   = 2 * smas_pkg::DIM_W;
  localparam int unsigned LC_W = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  logic [2:0] rows_q, rows_d;
  logic [2:0] inner_q, inner_d;
  logic [2:0] cols_q, cols_d;
  logic [1:0] op_q, op_d;
  logic [LC_W-1:0] lc_q, lc_d;

  logic            cfg_wr;
  logic            accept;
  smas_pkg::dims_t dims;
  logic [SW-1:0]   size_a, size_b, lc_ext, bi;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign accept      = push && !cmd_full_i;
  assign full        = cmd_full_i;

  always_comb begin
    dims.rows  = smas_pkg::clamp_dim(rows_q, smas_pkg::DIM_W'(MAX_DIM));
    dims.inner = smas_pkg::clamp_dim(inner_q, smas_pkg::DIM_W'(MAX_DIM));
    dims.cols  = smas_pkg::clamp_dim(cols_q, smas_pkg::DIM_W'(MAX_DIM));
    dims.mul   = op_q[smas_pkg::OP_MUL_BIT];
    dims.sub   = !op_q[smas_pkg::OP_MUL_BIT] && op_q[smas_pkg::OP_SUB_BIT];
  end
  assign dims_o = dims;

  assign size_a = SW'(dims.rows) * SW'(dims.inner);
  assign size_b = dims.mul ? SW'(dims.inner) * SW'(dims.cols) : size_a;
  assign lc_ext = SW'(lc_q);
  assign bi     = lc_ext - size_a;

  always_comb begin
    rows_d  = rows_q;
    inner_d = inner_q;
    cols_d  = cols_q;
    op_d    = op_q;
    lc_d    = lc_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = smas_pkg::CMD_WR_A;
    cmd_o.addr  = smas_pkg::CMD_ADDR_W'(lc_q);
    cmd_o.data  = in_item_i.elem_value;
    if (cfg_wr) begin
      unique case (smas_pkg::cfg_idx_e'(cfg_index_i))
        smas_pkg::CFG_ROWS:  rows_d  = cfg_data_i;
        smas_pkg::CFG_INNER: inner_d = cfg_data_i;
        smas_pkg::CFG_COLS:  cols_d  = cfg_data_i;
        smas_pkg::CFG_OP:    op_d    = cfg_data_i[1:0];
        default:             op_d    = op_q;
      endcase
      // any write abandons a partial load
      lc_d = '0;
    end else if (accept) begin
      if (lc_ext < size_a) begin
        if (!in_item_i.which_matrix) begin
          cmd_valid_o = 1'b1;
          lc_d        = lc_q + 1'b1;
        end
      end else if (in_item_i.which_matrix) begin
        if (bi >= size_b) begin
          lc_d = '0;
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.addr  = smas_pkg::CMD_ADDR_W'(bi);
          if (bi + 1'b1 == size_b) begin
            cmd_o.kind = smas_pkg::CMD_WR_B_RUN;
            lc_d       = '0;
          end else begin
            cmd_o.kind = smas_pkg::CMD_WR_B;
            lc_d       = lc_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= smas_pkg::ROWS_RST;
      inner_q <= smas_pkg::INNER_RST;
      cols_q  <= smas_pkg::COLS_RST;
      op_q    <= smas_pkg::OP_RST;
      lc_q    <= '0;
    end else begin
      rows_q  <= rows_d;
      inner_q <= inner_d;
      cols_q  <= cols_d;
      op_q    <= op_d;
      lc_q    <= lc_d;
    end
  end

endmodule

// File: rtl/smas_cmd_fifo.sv
// small command queue between front end and compute back end
`timescale 1ns / 1ps
module smas_cmd_fifo #(
  parameter int unsigned DEPTH = smas_pkg::CMD_FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smas_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output smas_pkg::cmd_t data_o,
  output logic           empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  smas_pkg::cmd_t entries_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/smas_back.sv
// back end: matrix stores, burst sequencer, compute pipeline, result register
`timescale 1ns / 1ps
module smas_back #(
  parameter int unsigned MAX_DIM = smas_pkg::MAX_DIM_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smas_pkg::dims_t     dims_i,
  input  logic                cmd_empty_i,
  input  smas_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output smas_pkg::out_item_t out_item_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = 2 * smas_pkg::DIM_W;
  localparam int unsigned DW    = smas_pkg::DIM_W;
  localparam int unsigned EW    = smas_pkg::ELEM_W;
  localparam int unsigned RW    = smas_pkg::RESULT_W;

  logic signed [EW-1:0] mem_a [DEPTH];
  logic signed [EW-1:0] mem_b [DEPTH];

  smas_pkg::seq_state_e state_q, state_d;

  logic [DW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AW-1:0] a_row_q, a_row_d, a_addr_q, a_addr_d, b_addr_q, b_addr_d;

  logic          wr_a, wr_b, start, adv, issue;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] total;
  logic [AW-1:0] tot_m1;
  logic          last_i, last_j, last_k;

  smas_pkg::pipe_ctl_t ctl0, ctl1_q, ctl2_q;
  logic signed [EW-1:0] rd_a_q, rd_b_q;
  logic signed [RW-1:0] ext_a, ext_b, val2_q, acc_q, sum;

  logic                  out_vld_q;
  smas_pkg::out_item_t   out_q;

  // the whole compute pipeline holds while a result waits unpopped
  assign adv   = !out_vld_q || pop;
  assign issue = (state_q == smas_pkg::SEQ_RUN) && adv;
  assign wr_addr = AW'(cmd_i.addr);

  assign total  = dims_i.mul ? SW'(dims_i.rows) * SW'(dims_i.cols)
                             : SW'(dims_i.rows) * SW'(dims_i.inner);
  assign tot_m1 = AW'(total - 1'b1);
  assign last_i = (i_q == dims_i.rows - 1'b1);
  assign last_j = (j_q == dims_i.cols - 1'b1);
  assign last_k = (k_q == dims_i.inner - 1'b1);

  // issue-stage control
  always_comb begin
    ctl0.vld = (state_q == smas_pkg::SEQ_RUN);
    if (dims_i.mul) begin
      ctl0.first = (k_q == '0);
      ctl0.lastk = last_k;
      ctl0.last  = last_k && last_i && last_j;
    end else begin
      ctl0.first = 1'b1;
      ctl0.lastk = 1'b1;
      ctl0.last  = (a_addr_q == tot_m1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smas_pkg::SEQ_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind == smas_pkg::CMD_WR_B_RUN) begin
          state_d = smas_pkg::SEQ_RUN;
        end
      end
      smas_pkg::SEQ_RUN: begin
        if (adv && ctl0.last) begin
          state_d = smas_pkg::SEQ_IDLE;
        end
      end
      default: state_d = smas_pkg::SEQ_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    start     = 1'b0;
    unique case (state_q)
      smas_pkg::SEQ_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            smas_pkg::CMD_WR_A: wr_a = 1'b1;
            smas_pkg::CMD_WR_B: wr_b = 1'b1;
            smas_pkg::CMD_WR_B_RUN: begin
              wr_b  = 1'b1;
              start = 1'b1;
            end
            default: wr_a = 1'b0;
          endcase
        end
      end
      smas_pkg::SEQ_RUN: cmd_pop_o = 1'b0;
      default:           cmd_pop_o = 1'b0;
    endcase
  end

  // index walk: mul runs k per (i, j), a by 1, b by cols; add/sub step both by 1
  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    a_row_d  = a_row_q;
    a_addr_d = a_addr_q;
    b_addr_d = b_addr_q;
    if (start) begin
      i_d      = '0;
      j_d      = '0;
      k_d      = '0;
      a_row_d  = '0;
      a_addr_d = '0;
      b_addr_d = '0;
    end else if (issue) begin
      if (!dims_i.mul) begin
        a_addr_d = a_addr_q + 1'b1;
        b_addr_d = b_addr_q + 1'b1;
      end else if (!last_k) begin
        k_d      = k_q + 1'b1;
        a_addr_d = a_addr_q + 1'b1;
        b_addr_d = b_addr_q + AW'(dims_i.cols);
      end else begin
        k_d = '0;
        if (last_j) begin
          j_d      = '0;
          i_d      = i_q + 1'b1;
          a_row_d  = a_row_q + AW'(dims_i.inner);
          a_addr_d = a_row_q + AW'(dims_i.inner);
          b_addr_d = '0;
        end else begin
          j_d      = j_q + 1'b1;
          a_addr_d = a_row_q;
          b_addr_d = AW'(j_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= smas_pkg::SEQ_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_row_q  <= '0;
      a_addr_q <= '0;
      b_addr_q <= '0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      a_row_q  <= a_row_d;
      a_addr_q <= a_addr_d;
      b_addr_q <= b_addr_d;
    end
  end

  // stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= cmd_i.data;
    end
    if (issue) begin
      rd_a_q <= mem_a[a_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= cmd_i.data;
    end
    if (issue) begin
      rd_b_q <= mem_b[b_addr_q];
    end
  end

  assign ext_a = {{(RW - EW){rd_a_q[EW-1]}}, rd_a_q};
  assign ext_b = {{(RW - EW){rd_b_q[EW-1]}}, rd_b_q};
  assign sum   = (ctl2_q.first ? '0 : acc_q) + val2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q    <= '0;
      ctl2_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      ctl1_q    <= ctl0;
      ctl2_q    <= ctl1_q;
      out_vld_q <= ctl2_q.vld && ctl2_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dims_i.mul) begin
        val2_q <= ext_a * ext_b;
      end else if (dims_i.sub) begin
        val2_q <= ext_a - ext_b;
      end else begin
        val2_q <= ext_a + ext_b;
      end
      if (ctl2_q.vld) begin
        acc_q <= sum;
        if (ctl2_q.lastk) begin
          out_q.result_value <= sum;
          out_q.result_last  <= ctl2_q.last;
        end
      end
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

endmodule

// File: rtl/small_matrix_add_sub_mul.sv
// top level of the small integer matrix add, subtract and multiply unit
`timescale 1ns / 1ps
// usage:
//   elements come in on the push/full queue side, row-major, all of A
//   (which_matrix 0) and then all of B (which_matrix 1); an element aimed
//   at the wrong matrix is taken and dropped. the element that completes B
//   starts a burst that returns the whole result matrix row-major on the
//   empty/pop side, with result_last set on its final element.
//   configuration (rows, inner_count, cols, op_mode at index 0..3) goes in
//   on the cfg valid/ready channel, always ready; the user must write it only
//   while the unit is idle (the unit does not enforce this); any write restarts the load count.
// throughput: one element per cycle while loading, unless the command queue
//   is full. a burst issues one operand pair per cycle, while no result waits
//   unpopped, from the stores' single read ports, so add and subtract give one
//   result per cycle and multiply one result per inner_count operand pairs.
// result path: with the command queue empty the completing element passes
//   the command queue, store write, store read, arithmetic and result reg on
//   its way to the ports; multiply first accumulates inner_count pairs.
// reset: dimensions 2, 3, 2, operation add, load count zero, queue and
//   result register empty; store contents are undefined until loaded.
// stall: while a result sits unpopped the compute pipeline freezes; the
//   front keeps taking elements until the four-entry command queue fills.
module small_matrix_add_sub_mul #(
  parameter int unsigned MAX_DIM   = smas_pkg::MAX_DIM_DEF,
  parameter int unsigned CMD_DEPTH = smas_pkg::CMD_FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [smas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smas_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // element request side
  input  logic                            push,
  output logic                            full,
  input  smas_pkg::in_item_t              in_item_i,
  // result request side
  output logic                            empty,
  input  logic                            pop,
  output smas_pkg::out_item_t             out_item_o
);

  smas_pkg::dims_t dims;
  smas_pkg::cmd_t  cmd_in, cmd_out;
  logic            cmd_valid, cmd_full, cmd_empty, cmd_pop;

  // front: config registers, load count, classification of each request
  smas_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .dims_o      (dims),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // decouples loading from a running burst
  smas_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: stores, burst sequencer, arithmetic, result register
  smas_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

  // the front only issues a command when the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_valid |-> !cmd_full)
    else $error("command issued into a full queue");

  // the back only takes a command that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  // clamped dimensions stay within one and the dimension limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dims.rows != '0) && (dims.inner != '0) && (dims.cols != '0) &&
    (dims.rows <= smas_pkg::DIM_W'(MAX_DIM)) &&
    (dims.inner <= smas_pkg::DIM_W'(MAX_DIM)) &&
    (dims.cols <= smas_pkg::DIM_W'(MAX_DIM)))
    else $error("dimension outside its clamped range");

endmodule
